// ===== hdl/pidl_pkg.sv =====
// Package with the types, codes and sizes shared by the positional list block.
`timescale 1ns / 1ps

package pidl_pkg;

   // Number of cells in the row.
   localparam int CAPACITY = 16;
   // Cell index width and live-count width.
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   // Fixed field widths of the two channels.
   localparam int OPC_W = 3;
   localparam int POS_W = 5;
   localparam int VAL_W = 32;
   localparam int STS_W = 2;
   localparam int OCNT_W = 5;

   typedef enum logic [OPC_W-1:0] {
      OP_INSERT      = 3'd0,
      OP_APPEND      = 3'd1,
      OP_REMOVE      = 3'd2,
      OP_REMOVE_LAST = 3'd3,
      OP_SEARCH      = 3'd4
   } opcode_type;

   typedef enum logic [STS_W-1:0] {
      ST_OK      = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   // What a cell takes in at the next edge.
   typedef enum logic [1:0] {
      SEL_HOLD       = 2'd0,
      SEL_LOAD       = 2'd1,
      SEL_FROM_LOWER = 2'd2,
      SEL_FROM_UPPER = 2'd3
   } cell_sel_type;

   // Decoded outcome of one request beat.
   typedef struct packed {
      status_type       status;
      logic             search;
      logic [CNT_W-1:0] count_next;
   } ctrl_res_type;

endpackage

// ===== hdl/pidl_cell.sv =====
// One storage cell of the list row: holds, loads, or takes a neighbor's word.
`timescale 1ns / 1ps

module pidl_cell
   import pidl_pkg::*;
(
   input  logic                    clock,
   input  cell_sel_type            sel,
   input  logic signed [VAL_W-1:0] lower_value,
   input  logic signed [VAL_W-1:0] upper_value,
   input  logic signed [VAL_W-1:0] load_value,
   input  logic signed [VAL_W-1:0] key,
   output logic signed [VAL_W-1:0] value,
   output logic                    match
);

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   always_comb begin
      case (sel)
         SEL_LOAD:       value_in = load_value;
         SEL_FROM_LOWER: value_in = lower_value;
         SEL_FROM_UPPER: value_in = upper_value;
         default:        value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign match = (value_ff == key);

endmodule

// ===== hdl/pidl_ctrl.sv =====
// Request decoder: checks bounds, picks the new count and steers every cell.
`timescale 1ns / 1ps

module pidl_ctrl
   import pidl_pkg::*;
(
   input  logic                             fire,
   input  logic [OPC_W-1:0]                 opcode,
   input  logic [POS_W-1:0]                 position,
   input  logic [CNT_W-1:0]                 count,
   output ctrl_res_type                     res,
   output cell_sel_type [CAPACITY-1:0]      sel
);

   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   logic [CMP_W-1:0] pos_x;
   logic [CMP_W-1:0] cnt_x;
   logic             full;
   logic             empty;

   assign pos_x = CMP_W'(position);
   assign cnt_x = CMP_W'(count);
   assign full  = (count >= CNT_W'(CAPACITY));
   assign empty = (count == '0);

   always_comb begin
      res.status     = ST_OK;
      res.search     = 1'b0;
      res.count_next = count;
      for (int i = 0; i < CAPACITY; i++) begin
         sel[i] = SEL_HOLD;
      end
      case (opcode)
         OP_INSERT: begin
            if (full) begin
               res.status = ST_FULL;
            end else if (pos_x > cnt_x) begin
               res.status = ST_BAD_POS;
            end else begin
               res.count_next = count + 1'b1;
               // Cells from the position up to the old end move up one place.
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CMP_W'(i) == pos_x) begin
                     sel[i] = SEL_LOAD;
                  end else if (CMP_W'(i) > pos_x && CMP_W'(i) <= cnt_x) begin
                     sel[i] = SEL_FROM_LOWER;
                  end
               end
            end
         end
         OP_APPEND: begin
            if (full) begin
               res.status = ST_FULL;
            end else begin
               res.count_next = count + 1'b1;
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CMP_W'(i) == cnt_x) begin
                     sel[i] = SEL_LOAD;
                  end
               end
            end
         end
         OP_REMOVE: begin
            if (empty) begin
               res.status = ST_EMPTY;
            end else if (pos_x >= cnt_x) begin
               res.status = ST_BAD_POS;
            end else begin
               res.count_next = count - 1'b1;
               // The old last cell keeps a stale word; it is no longer live.
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CMP_W'(i) >= pos_x && CMP_W'(i) + 1'b1 < cnt_x) begin
                     sel[i] = SEL_FROM_UPPER;
                  end
               end
            end
         end
         OP_REMOVE_LAST: begin
            if (empty) begin
               res.status = ST_EMPTY;
            end else begin
               res.count_next = count - 1'b1;
            end
         end
         OP_SEARCH: begin
            res.search = 1'b1;
         end
         default: begin
            res.status = ST_OK;
         end
      endcase
      if (!fire) begin
         for (int i = 0; i < CAPACITY; i++) begin
            sel[i] = SEL_HOLD;
         end
         res.count_next = count;
      end
   end

endmodule

// ===== hdl/positional_insert_delete_list.sv =====
// Top level of the positional list: cell row, count register and result stages.
// A request beat passes the first stage register and then the output register, which
// holds the result beat until rsp_ready takes it. Throughput: one beat per cycle while
// rsp_ready does not stall them; the whole cell row shifts, holds or loads at once.
// The middle entry is read from the updated row once the first stage moves on, then registered.
// Reset clears the live count and both valid flags; cell contents stay undefined.
`timescale 1ns / 1ps

module positional_insert_delete_list
   import pidl_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OPC_W-1:0]         req_opcode,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [VAL_W-1:0]  req_item_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [STS_W-1:0]         rsp_status,
   output logic                     rsp_found,
   output logic [OCNT_W-1:0]        rsp_count,
   output logic signed [VAL_W-1:0]  rsp_middle_value
);

   logic                        fire;
   logic                        s1_advance;
   ctrl_res_type                res;
   cell_sel_type [CAPACITY-1:0] sel;
   logic signed [VAL_W-1:0]     cell_value [CAPACITY];
   logic [CAPACITY-1:0]         cell_match;
   logic                        hit;
   logic [IDX_W-1:0]            mid_idx;
   logic signed [VAL_W-1:0]     middle;

   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   status_type                  s1_status_ff;
   logic                        s1_found_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   status_type                  rsp_status_ff;
   logic                        rsp_found_ff;
   logic [CNT_W-1:0]            rsp_count_ff;
   logic signed [VAL_W-1:0]     rsp_middle_ff;

   // The first stage may only move on when the output register is free.
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign fire       = req_valid && req_ready;

   pidl_ctrl u_ctrl (
      .fire     (fire),
      .opcode   (req_opcode),
      .position (req_position),
      .count    (count_ff),
      .res      (res),
      .sel      (sel)
   );

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [VAL_W-1:0] lower;
      logic signed [VAL_W-1:0] upper;
      if (g == 0) begin : g_first
         assign lower = '0;
      end else begin : g_mid_lo
         assign lower = cell_value[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign upper = '0;
      end else begin : g_mid_hi
         assign upper = cell_value[g+1];
      end
      pidl_cell u_cell (
         .clock       (clock),
         .sel         (sel[g]),
         .lower_value (lower),
         .upper_value (upper),
         .load_value  (req_item_value),
         .key         (req_item_value),
         .value       (cell_value[g]),
         .match       (cell_match[g])
      );
   end

   // Search looks only at live cells, before this beat changes anything.
   always_comb begin
      hit = 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_match[i] && CNT_W'(i) < count_ff) begin
            hit = 1'b1;
         end
      end
   end

   assign mid_idx = IDX_W'(count_ff >> 1);
   assign middle  = (count_ff == '0) ? '0 : cell_value[mid_idx];

   assign count_in     = res.count_next;
   assign s1_valid_in  = fire || (s1_valid_ff && !s1_advance);
   assign rsp_valid_in = s1_advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         s1_status_ff <= res.status;
         s1_found_ff  <= res.search && hit;
      end
      // The row already holds this beat's result, since nothing new entered behind it.
      if (s1_advance) begin
         rsp_status_ff <= s1_status_ff;
         rsp_found_ff  <= s1_found_ff;
         rsp_count_ff  <= count_ff;
         rsp_middle_ff <= middle;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_count        = OCNT_W'(rsp_count_ff);
   assign rsp_middle_value = rsp_middle_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("live count beyond capacity");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      fire && res.status != ST_OK |=> count_ff == $past(count_ff))
      else $error("rejected beat changed the count");

   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_count_ff == $past(count_ff))
      else $error("result count does not match list");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_found_ff |-> rsp_status_ff == ST_OK)
      else $error("hit reported with error status");

   a_empty_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_count_ff == '0 |-> rsp_middle_ff == '0)
      else $error("empty list gave nonzero middle");

endmodule
